>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define TEA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TEA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tea_pkg.sv
// ---------------------------------------------------------------------------
// tea_pkg
// Shared types and constants for the temporal earliest-arrival search.
// ---------------------------------------------------------------------------
package tea_pkg;

	// Field widths fixed by the interface
	localparam int VTX_W      = 10;
	localparam int TIME_W     = 31;
	localparam int VCNT_W     = 11;
	localparam int ARR_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// Wide enough to hold any vertex count up to the largest supported depth
	localparam int CNT_W      = 17;

	// Search generation tag kept next to each stored arrival
	localparam int EPOCH_W    = 8;

	// Parameter defaults
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int TIME_BITS_DEF    = 31;
	localparam logic [VCNT_W-1:0] VCOUNT_RST = 11'd1024;

	// Request codes
	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_EDGE  = 2'd1,
		FUNC_READ  = 2'd2
	} func_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE = 2'd0,
		CFG_START  = 2'd1,
		CFG_WINDOW = 2'd2,
		CFG_VCOUNT = 2'd3
	} cfg_idx_t;

	// One result
	typedef struct packed {
		logic             reached;
		logic [ARR_W-1:0] arrival;
		logic             improved;
		logic             stopped;
	} result_t;

endpackage

>>> rtl/core/tea_mem.sv
// ---------------------------------------------------------------------------
// tea_mem
// Arrival/tag store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module tea_mem #(
	parameter int DEPTH = tea_pkg::MAX_VERTICES_DEF,
	parameter int DW    = tea_pkg::TIME_BITS_DEF + tea_pkg::EPOCH_W,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, old data on a same-edge write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

>>> rtl/core/temporal_earliest_arrival.sv
// ---------------------------------------------------------------------------
// temporal_earliest_arrival: one-pass earliest-arrival search, ordered edges
// Stage-1 registers hold each request, the output register its result.
// Throughput: one request per cycle when not stalled or clearing, set by the
//   stage-1 compare path and the store's two read ports plus one write port
//   (with write forwarding). Reset: control and config registers reset at once
//   and a pass then clears the store tags; every 255th start repeats it.
// ---------------------------------------------------------------------------
module temporal_earliest_arrival #(
	parameter int MAX_VERTICES = tea_pkg::MAX_VERTICES_DEF,
	parameter int TIME_BITS    = tea_pkg::TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tea_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tea_pkg::CFG_DATA_W-1:0]      cfg_data,
	// requests
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          func,
	input  logic [tea_pkg::VTX_W-1:0]           from_vertex,
	input  logic [tea_pkg::VTX_W-1:0]           to_vertex,
	input  logic [tea_pkg::TIME_W-1:0]          depart_time,
	input  logic [tea_pkg::TIME_W-1:0]          duration,
	// results
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                reached,
	output logic signed [tea_pkg::ARR_W-1:0]    arrival,
	output logic                                improved,
	output logic                                stopped
);

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int EW    = tea_pkg::EPOCH_W;
	localparam int MW    = TIME_BITS + EW;
	localparam int TW    = tea_pkg::TIME_W;
	localparam int RW    = tea_pkg::ARR_W;
	localparam int CW    = tea_pkg::CNT_W;
	localparam int VW    = tea_pkg::VTX_W;
	localparam int CMPW  = (TIME_BITS > RW) ? TIME_BITS : RW;
	localparam logic [TW-1:0] TMASK = (TIME_BITS >= TW) ? '1 :
		TW'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [CW-1:0] MAXV        = CW'(MAX_VERTICES);
	localparam logic [AW-1:0] LAST_ADDR   = AW'(MAX_VERTICES - 1);
	localparam logic [EW-1:0] EPOCH_FIRST = EW'(1);
	localparam logic [EW-1:0] EPOCH_LAST  = '1;

	// Configuration registers
	logic [VW-1:0]                  src_q;
	logic [TW-1:0]                  start_q;
	logic [TW-1:0]                  wend_q;
	logic [tea_pkg::VCNT_W-1:0]     vcnt_q;

	// Search state
	logic [EW-1:0]  epoch_q;
	logic           stop_q;

	// Tag clearing pass
	logic           sweep_q;
	logic [AW-1:0]  sw_cnt_q;
	logic [AW-1:0]  sw_src_q;
	logic           sw_src_ok_q;
	logic [TIME_BITS-1:0] sw_time_q;

	// Last store write, for forwarding
	logic           wr_vld_q;
	logic [AW-1:0]  wr_addr_q;
	logic [MW-1:0]  wr_data_q;

	// Stage 1
	logic                  s1_valid_q;
	tea_pkg::func_t        func_s1;
	logic [VW-1:0]         u_s1;
	logic [VW-1:0]         v_s1;
	logic [TW-1:0]         dep_s1;
	logic [RW-1:0]         sum_s1;

	// Output register
	logic                  out_valid_q;
	tea_pkg::result_t      res_q;

	// Handshake
	logic in_acc;
	logic s1_adv;
	logic sweep_req;

	// Store ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [MW-1:0] mem_wdata;
	logic [AW-1:0] rd_addr_u;
	logic [AW-1:0] rd_addr_v;
	logic [MW-1:0] rd_u;
	logic [MW-1:0] rd_v;
	logic [CW-1:0] from_ext;
	logic [CW-1:0] to_ext;

	// Stage-1 decode
	logic [CW-1:0]        active_cnt;
	logic [CW-1:0]        u_ext;
	logic [CW-1:0]        v_ext;
	logic [CW-1:0]        src_ext;
	logic [AW-1:0]        ua_s1;
	logic [AW-1:0]        va_s1;
	logic [AW-1:0]        src_addr;
	logic [MW-1:0]        fwd_u;
	logic [MW-1:0]        fwd_v;
	logic                 u_in;
	logic                 v_in;
	logic                 src_in;
	logic                 u_hit;
	logic                 v_hit;
	logic [TIME_BITS-1:0] u_time;
	logic [TIME_BITS-1:0] v_time;
	logic [TIME_BITS-1:0] start_t;
	logic [TIME_BITS-1:0] sum_store;
	logic [CMPW-1:0]      dep_c;
	logic [CMPW-1:0]      sum_c;
	logic [CMPW-1:0]      wend_c;
	logic                 usable;
	logic                 better;
	logic                 stop_set;
	logic                 n_we;
	logic [AW-1:0]        n_waddr;
	logic [MW-1:0]        n_wdata;
	tea_pkg::result_t     res;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q   <= '0;
			start_q <= '0;
			wend_q  <= '0;
			vcnt_q  <= tea_pkg::VCOUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tea_pkg::cfg_idx_t'(cfg_index))
				tea_pkg::CFG_SOURCE: src_q   <= cfg_data[VW-1:0];
				tea_pkg::CFG_START:  start_q <= cfg_data;
				tea_pkg::CFG_WINDOW: wend_q  <= cfg_data;
				tea_pkg::CFG_VCOUNT: vcnt_q  <= cfg_data[tea_pkg::VCNT_W-1:0];
			endcase
		end
	end

	// Handshake
	assign sweep_req = s1_valid_q && (func_s1 == tea_pkg::FUNC_START) &&
		(epoch_q == EPOCH_LAST);
	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !sweep_q && !sweep_req && (!s1_valid_q || s1_adv);
	assign in_acc   = in_valid && in_ready;

	// Read addresses straight from the request ports
	assign from_ext  = CW'(from_vertex);
	assign to_ext    = CW'(to_vertex);
	assign rd_addr_u = from_ext[AW-1:0];
	assign rd_addr_v = to_ext[AW-1:0];

	// Stage 1 capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= tea_pkg::func_t'(func);
			u_s1    <= from_vertex;
			v_s1    <= to_vertex;
			dep_s1  <= depart_time & TMASK;
			sum_s1  <= {1'b0, depart_time & TMASK} + {1'b0, duration & TMASK};
		end
	end

	// Range checks against the active vertex count
	assign active_cnt = (CW'(vcnt_q) > MAXV) ? MAXV : CW'(vcnt_q);
	assign u_ext      = CW'(u_s1);
	assign v_ext      = CW'(v_s1);
	assign src_ext    = CW'(src_q);
	assign ua_s1      = u_ext[AW-1:0];
	assign va_s1      = v_ext[AW-1:0];
	assign src_addr   = src_ext[AW-1:0];
	assign u_in       = u_ext < active_cnt;
	assign v_in       = v_ext < active_cnt;
	assign src_in     = src_ext < active_cnt;

	// Forward the last write over the registered read
	assign fwd_u = (wr_vld_q && (wr_addr_q == ua_s1)) ? wr_data_q : rd_u;
	assign fwd_v = (wr_vld_q && (wr_addr_q == va_s1)) ? wr_data_q : rd_v;

	// Entry is reached when its tag matches the current search
	assign u_time = fwd_u[TIME_BITS-1:0];
	assign v_time = fwd_v[TIME_BITS-1:0];
	assign u_hit  = u_in && (fwd_u[MW-1:TIME_BITS] == epoch_q);
	assign v_hit  = v_in && (fwd_v[MW-1:TIME_BITS] == epoch_q);

	// Edge relaxation
	assign start_t   = TIME_BITS'(start_q);
	assign dep_c     = CMPW'(dep_s1);
	assign sum_c     = CMPW'(sum_s1);
	assign wend_c    = CMPW'(wend_q & TMASK);
	assign sum_store = TIME_BITS'(sum_c);
	assign usable    = (sum_c <= wend_c) && u_hit && v_in && (dep_c >= CMPW'(u_time));
	assign better    = usable && (!v_hit || (sum_c < CMPW'(v_time)));
	assign stop_set  = !usable && (dep_c >= wend_c);

	// Result and store update of the request in stage 1
	always_comb begin
		res      = '0;
		n_we     = 1'b0;
		n_waddr  = va_s1;
		n_wdata  = {epoch_q, sum_store};
		unique case (func_s1)
			tea_pkg::FUNC_START: begin
				res.reached  = src_in;
				res.arrival  = src_in ? RW'(start_t) : '1;
				res.improved = 1'b0;
				res.stopped  = 1'b0;
				n_we         = src_in && !sweep_req;
				n_waddr      = src_addr;
				n_wdata      = {epoch_q + EW'(1), start_t};
			end
			tea_pkg::FUNC_EDGE: begin
				if (stop_q) begin
					res.reached  = v_hit;
					res.arrival  = v_hit ? RW'(v_time) : '1;
					res.improved = 1'b0;
					res.stopped  = 1'b1;
				end else if (better) begin
					res.reached  = 1'b1;
					res.arrival  = RW'(sum_store);
					res.improved = 1'b1;
					res.stopped  = 1'b0;
					n_we         = 1'b1;
				end else begin
					res.reached  = v_hit;
					res.arrival  = v_hit ? RW'(v_time) : '1;
					res.improved = 1'b0;
					res.stopped  = stop_set;
				end
			end
			tea_pkg::FUNC_READ: begin
				res.reached  = u_hit;
				res.arrival  = u_hit ? RW'(u_time) : '1;
				res.improved = 1'b0;
				res.stopped  = stop_q;
			end
			default: begin
				res.reached  = 1'b0;
				res.arrival  = '1;
				res.improved = 1'b0;
				res.stopped  = stop_q;
			end
		endcase
	end

	// Search state, clearing pass and forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q     <= EPOCH_FIRST;
			stop_q      <= 1'b0;
			sweep_q     <= 1'b1;
			sw_cnt_q    <= '0;
			sw_src_q    <= '0;
			sw_src_ok_q <= 1'b0;
			sw_time_q   <= '0;
			wr_vld_q    <= 1'b0;
			wr_addr_q   <= '0;
			wr_data_q   <= '0;
		end else begin
			if (sweep_q) begin
				sw_cnt_q <= sw_cnt_q + AW'(1);
				if (sw_cnt_q == LAST_ADDR) begin
					sweep_q <= 1'b0;
				end
			end
			if (s1_adv) begin
				if (n_we) begin
					wr_vld_q  <= 1'b1;
					wr_addr_q <= n_waddr;
					wr_data_q <= n_wdata;
				end
				if (func_s1 == tea_pkg::FUNC_START) begin
					stop_q <= 1'b0;
					if (sweep_req) begin
						// Tags exhausted: restart at the first epoch behind a full clear
						epoch_q     <= EPOCH_FIRST;
						sweep_q     <= 1'b1;
						sw_cnt_q    <= '0;
						sw_src_q    <= src_addr;
						sw_src_ok_q <= src_in;
						sw_time_q   <= start_t;
						wr_vld_q    <= 1'b0;
					end else begin
						epoch_q <= epoch_q + EW'(1);
					end
				end else if ((func_s1 == tea_pkg::FUNC_EDGE) && !stop_q && stop_set) begin
					stop_q <= 1'b1;
				end
			end
		end
	end

	// Store write select: clearing pass or stage-1 update
	always_comb begin
		if (sweep_q) begin
			mem_we    = 1'b1;
			mem_waddr = sw_cnt_q;
			mem_wdata = (sw_src_ok_q && (sw_cnt_q == sw_src_q)) ?
				{EPOCH_FIRST, sw_time_q} : '0;
		end else begin
			mem_we    = s1_adv && n_we;
			mem_waddr = n_waddr;
			mem_wdata = n_wdata;
		end
	end

	tea_mem #(
		.DEPTH (MAX_VERTICES),
		.DW    (MW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (in_acc),
		.raddr_a (rd_addr_u),
		.raddr_b (rd_addr_v),
		.rdata_a (rd_u),
		.rdata_b (rd_v)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign reached   = res_q.reached;
	assign arrival   = res_q.arrival;
	assign improved  = res_q.improved;
	assign stopped   = res_q.stopped;

endmodule

>>> rtl/core/tea_chk.sv
// ---------------------------------------------------------------------------
// tea_chk
// Port-level checks on the earliest-arrival block's result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tea_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [tea_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [tea_pkg::CFG_DATA_W-1:0]   cfg_data,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [1:0]                       func,
	input logic [tea_pkg::VTX_W-1:0]        from_vertex,
	input logic [tea_pkg::VTX_W-1:0]        to_vertex,
	input logic [tea_pkg::TIME_W-1:0]       depart_time,
	input logic [tea_pkg::TIME_W-1:0]       duration,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             reached,
	input logic signed [tea_pkg::ARR_W-1:0] arrival,
	input logic                             improved,
	input logic                             stopped
);

	// Stalled result holds
	`TEA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(arrival) && $stable(reached) && $stable(improved) && $stable(stopped), "result changed while stalled")

	// Unreached vertex reports the all-ones arrival
	`TEA_ASSERT_IMP(a_unreached_arr, out_valid && !reached, arrival == '1, "unreached arrival not -1")

	// An improvement always leaves the target reached
	`TEA_ASSERT_IMP(a_improved_reached, out_valid && improved, reached, "improved without reached")

	// No improvement once the window has closed
	`TEA_ASSERT_IMP(a_improved_live, out_valid && improved, !stopped, "improved while stopped")

endmodule

bind temporal_earliest_arrival tea_chk u_tea_chk (.*);
